// ----- rtl/core/stp_pkg.sv -----
// shared types, constants and helpers of the short-term plasticity synapse
`default_nettype none

package stp_pkg;

    localparam int SYN_DEPTH   = 65536;
    localparam int SYN_AW      = $clog2(SYN_DEPTH);
    localparam int NEUR_W      = 12;
    localparam int Q_W         = 16;
    localparam int INC_W       = 24;
    localparam int EXC_CNT_W   = 13;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int STATE_W     = 2 * Q_W;

    localparam logic [Q_W-1:0] ONE_Q15 = 16'd32768;

    localparam logic [Q_W-1:0]       RST_DECAY    = 16'd22;
    localparam logic [Q_W-1:0]       RST_RECOVERY = 16'd13;
    localparam logic [Q_W-1:0]       RST_RELEASE  = 16'd39322;
    localparam logic [Q_W-1:0]       RST_GAIN_EXC = 16'd256;
    localparam logic [Q_W-1:0]       RST_GAIN_INH = 16'd256;
    localparam logic [EXC_CNT_W-1:0] RST_EXC_CNT  = 13'd3200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECAY     = 3'd0,
        CFG_RECOVERY  = 3'd1,
        CFG_RELEASE   = 3'd2,
        CFG_GAIN_EXC  = 3'd3,
        CFG_GAIN_INH  = 3'd4,
        CFG_EXC_COUNT = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [Q_W-1:0]       decay_factor;
        logic [Q_W-1:0]       recovery_factor;
        logic [Q_W-1:0]       release_step;
        logic [Q_W-1:0]       gain_excitatory;
        logic [Q_W-1:0]       gain_inhibitory;
        logic [EXC_CNT_W-1:0] excitatory_count;
    } t_cfg;

    // classified request as it travels from front to back
    typedef struct packed {
        logic [SYN_AW-1:0] idx;
        logic [NEUR_W-1:0] dest;
        logic              exc;
        logic              spike;
    } t_item;

    typedef struct packed {
        logic [NEUR_W-1:0] dest;
        logic              exc;
        logic [INC_W-1:0]  increment;
    } t_result;

    // distance to one in q1.15, values at or above one give zero
    function automatic logic [Q_W-1:0] headroom(input logic [Q_W-1:0] v);
        logic [Q_W-1:0] h;
        if (v >= ONE_Q15) begin
            h = '0;
        end else begin
            h = ONE_Q15 - v;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/short_term_plasticity_synapse.sv -----
// Tsodyks-Markram short-term plasticity synapse, one synapse state update per request.
// Slave stream s_axis carries one update: synapse index, source and target neuron in
// tdata and the presynaptic spike flag in tuser. Master stream m_axis carries one
// conductance increment per spiking update: target neuron and Q8.16 increment in tdata,
// the excitatory flag in tuser. Updates without a spike change state but send nothing.
// Parameters are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must do so
// only while the block idles; the block itself does not enforce it. Throughput: one
// request per cycle while the queue is not full and no clearing sweep runs. A request
// for a synapse that is still in the five-stage update pipeline waits until its state
// is written back. A result reaches m_axis through the queue, the registered state
// memory read and the chain of four multiplies. After reset a sweep writes utilization
// zero and resources one into all 65536 state entries, one per cycle; s_axis_tready
// stays low until the sweep is done. When m_axis stalls the pipeline holds; the
// four-entry queue keeps accepting requests until it fills, then s_axis_tready drops.
`default_nettype none

module short_term_plasticity_synapse
    import stp_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // synapse_index[15:0], source_neuron[27:16], target_neuron[39:28]
    input  wire logic [39:0]           s_axis_tdata,
    // spiked[0]
    input  wire logic                  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // dest_neuron[11:0], increment[35:12], zero[39:36]
    output logic [39:0]                m_axis_tdata,
    // is_excitatory[0]
    output logic                       m_axis_tuser
);

    t_cfg    r_cfg;
    logic    clr_busy;
    logic    q_valid, q_pop;
    t_item   q_item;
    t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decay_factor     <= RST_DECAY;
            r_cfg.recovery_factor  <= RST_RECOVERY;
            r_cfg.release_step     <= RST_RELEASE;
            r_cfg.gain_excitatory  <= RST_GAIN_EXC;
            r_cfg.gain_inhibitory  <= RST_GAIN_INH;
            r_cfg.excitatory_count <= RST_EXC_CNT;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_DECAY:     r_cfg.decay_factor     <= i_cfg_data;
                CFG_RECOVERY:  r_cfg.recovery_factor  <= i_cfg_data;
                CFG_RELEASE:   r_cfg.release_step     <= i_cfg_data;
                CFG_GAIN_EXC:  r_cfg.gain_excitatory  <= i_cfg_data;
                CFG_GAIN_INH:  r_cfg.gain_inhibitory  <= i_cfg_data;
                CFG_EXC_COUNT: r_cfg.excitatory_count <= i_cfg_data[EXC_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    stp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_clr_busy (clr_busy),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_idx      (s_axis_tdata[15:0]),
        .i_src      (s_axis_tdata[27:16]),
        .i_dst      (s_axis_tdata[39:28]),
        .i_spike    (s_axis_tuser),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    stp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .o_clr_busy (clr_busy),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_q_pop    (q_pop),
        .o_valid    (m_axis_tvalid),
        .o_result   (result),
        .i_ready    (m_axis_tready)
    );

    assign m_axis_tdata = {4'b0, result.increment, result.dest};
    assign m_axis_tuser = result.exc;

endmodule

`default_nettype wire

// ----- rtl/core/stp_ram.sv -----
// generic single-port-write, registered-read ram
`default_nettype none

module stp_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [W-1:0]             i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/stp_front.sv -----
// front end: accepts requests, classifies source neuron, queues them for the back end
`default_nettype none

module stp_front
    import stp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cfg              i_cfg,
    input  wire logic              i_clr_busy,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [SYN_AW-1:0] i_idx,
    input  wire logic [NEUR_W-1:0] i_src,
    input  wire logic [NEUR_W-1:0] i_dst,
    input  wire logic              i_spike,
    output logic                   o_q_valid,
    output t_item                  o_q_item,
    input  wire logic              i_q_pop
);

    t_item                r_queue [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QUEUE_AW:0]    r_count, n_count;
    logic                 push;
    t_item                item;

    assign o_ready = !i_clr_busy && (r_count != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push    = i_valid && o_ready;

    always_comb begin
        item.idx   = i_idx;
        item.dest  = i_dst;
        item.exc   = {1'b0, i_src} < i_cfg.excitatory_count;
        item.spike = i_spike;
    end

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + QUEUE_AW'(1) : r_wr_ptr;
        n_rd_ptr = i_q_pop ? r_rd_ptr + QUEUE_AW'(1) : r_rd_ptr;
        n_count  = r_count + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= item;
        end
    end

    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_queue[r_rd_ptr];

endmodule

`default_nettype wire

// ----- rtl/core/stp_back.sv -----
// back end: state memory, clearing sweep and the update pipeline
`default_nettype none

module stp_back
    import stp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cfg    i_cfg,
    output logic         o_clr_busy,
    input  wire logic    i_q_valid,
    input  wire t_item   i_q_item,
    output logic         o_q_pop,
    output logic         o_valid,
    output t_result      o_result,
    input  wire logic    i_ready
);

    // clearing sweep
    logic              r_clr_busy;
    logic [SYN_AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + SYN_AW'(1);
            if (r_clr_addr == SYN_AW'(SYN_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign o_clr_busy = r_clr_busy;

    // pipeline registers
    logic              r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid, r_s5_valid;
    t_item             r_s1_item, r_s2_item, r_s3_item, r_s4_item, r_s5_item;
    logic [Q_W-1:0]    r_s2_u, r_s2_x, r_s2_pd, r_s2_pr;
    logic [Q_W-1:0]    r_s3_u, r_s3_x, r_s3_pf;
    logic [Q_W-1:0]    r_s4_u, r_s4_x;
    logic [2*Q_W-1:0]  r_s4_prod;
    logic [2*Q_W-1:0]  r_s5_prod;
    logic              r_out_valid;
    t_result           r_out;

    logic              adv, hazard, issue;
    logic [STATE_W-1:0] rd_data;
    logic [Q_W-1:0]    s1_u, s1_x;
    logic [2*Q_W-1:0]  s1_pd, s1_pr;
    logic [Q_W-1:0]    s2_u, s2_x;
    logic [2*Q_W-1:0]  s2_pf;
    logic [Q_W-1:0]    s3_u;
    logic [2*Q_W-1:0]  s3_prod;
    logic [Q_W:0]      s4_rraw;
    logic [Q_W-1:0]    s4_r, s4_x;
    logic [Q_W-1:0]    s4_gain;
    logic [2*Q_W-1:0]  s4_prod;
    logic [2*Q_W-8:0]  s5_inc;
    logic [INC_W-1:0]  s5_sat;
    logic              ram_we;
    logic [SYN_AW-1:0] ram_waddr;
    logic [STATE_W-1:0] ram_wdata;

    assign adv = !r_out_valid || i_ready;

    // same synapse still in flight: hold issue until it is written back
    assign hazard = (r_s1_valid && r_s1_item.idx == i_q_item.idx)
                 || (r_s2_valid && r_s2_item.idx == i_q_item.idx)
                 || (r_s3_valid && r_s3_item.idx == i_q_item.idx)
                 || (r_s4_valid && r_s4_item.idx == i_q_item.idx);

    assign issue   = adv && i_q_valid && !hazard && !r_clr_busy;
    assign o_q_pop = issue;

    // stage 1: state read, decay and recovery products
    assign s1_u  = rd_data[Q_W-1:0];
    assign s1_x  = rd_data[STATE_W-1:Q_W];
    assign s1_pd = s1_u * i_cfg.decay_factor;
    assign s1_pr = headroom(s1_x) * i_cfg.recovery_factor;

    // stage 2: apply decay and recovery, facilitation product
    assign s2_u  = r_s2_u - r_s2_pd;
    assign s2_x  = r_s2_x + r_s2_pr;
    assign s2_pf = headroom(s2_u) * i_cfg.release_step;

    // stage 3: facilitate on spike, release product
    assign s3_u    = r_s3_item.spike ? r_s3_u + r_s3_pf : r_s3_u;
    assign s3_prod = s3_u * r_s3_x;

    // stage 4: release, write back, gain product
    assign s4_rraw = r_s4_prod[2*Q_W-1:Q_W-1];
    assign s4_r    = (s4_rraw > {1'b0, r_s4_x}) ? r_s4_x : s4_rraw[Q_W-1:0];
    assign s4_x    = r_s4_item.spike ? r_s4_x - s4_r : r_s4_x;
    assign s4_gain = r_s4_item.exc ? i_cfg.gain_excitatory : i_cfg.gain_inhibitory;
    assign s4_prod = s4_r * s4_gain;

    // stage 5: scale and saturate
    assign s5_inc = r_s5_prod[2*Q_W-1:7];
    assign s5_sat = (s5_inc[2*Q_W-8:INC_W] != '0) ? '1 : s5_inc[INC_W-1:0];

    always_comb begin
        if (r_clr_busy) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = {ONE_Q15, Q_W'(0)};
        end else begin
            ram_we    = adv && r_s4_valid;
            ram_waddr = r_s4_item.idx;
            ram_wdata = {s4_x, r_s4_u};
        end
    end

    stp_ram #(
        .W     (STATE_W),
        .DEPTH (SYN_DEPTH)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (adv),
        .i_raddr (i_q_item.idx),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= issue;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_s5_valid  <= r_s4_valid;
            r_out_valid <= r_s5_valid && r_s5_item.spike;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_item <= i_q_item;
            r_s2_item <= r_s1_item;
            r_s2_u    <= s1_u;
            r_s2_x    <= s1_x;
            r_s2_pd   <= s1_pd[2*Q_W-1:Q_W];
            r_s2_pr   <= s1_pr[2*Q_W-1:Q_W];
            r_s3_item <= r_s2_item;
            r_s3_u    <= s2_u;
            r_s3_x    <= s2_x;
            r_s3_pf   <= s2_pf[2*Q_W-1:Q_W];
            r_s4_item <= r_s3_item;
            r_s4_u    <= s3_u;
            r_s4_x    <= r_s3_x;
            r_s4_prod <= s3_prod;
            r_s5_item <= r_s4_item;
            r_s5_prod <= s4_prod;
            r_out.dest      <= r_s5_item.dest;
            r_out.exc       <= r_s5_item.exc;
            r_out.increment <= s5_sat;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

// ----- tb/sv/tb_short_term_plasticity_synapse.sv -----
// testbench of the short-term plasticity synapse: stream traffic checked against a bit-true predictor
module tb_short_term_plasticity_synapse;
    timeunit 1ns;
    timeprecision 1ps;
    import stp_pkg::*;

    localparam int          CYCLE_LIMIT   = 800000;
    localparam int          SETTLE_CYCLES = 200;
    localparam logic [31:0] Q15_ONE       = 32'd32768;
    localparam logic [31:0] INC_CEIL      = 32'h00FF_FFFF;

    typedef enum int {
        FLOW_FREE,
        FLOW_SRC_IDLE,
        FLOW_SINK_STALL,
        FLOW_BOTH_IDLE
    } t_flow;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [39:0]           m_axis_tdata;
    logic                  m_axis_tuser;

    // shadow of the configuration registers
    logic [15:0] cfg_decay;
    logic [15:0] cfg_recovery;
    logic [15:0] cfg_release;
    logic [15:0] cfg_gain_exc;
    logic [15:0] cfg_gain_inh;
    logic [12:0] cfg_exc_count;

    // per-synapse state, q1.15
    logic [15:0] util_q15 [SYN_DEPTH];
    logic [15:0] res_q15  [SYN_DEPTH];

    t_result increment_q [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int err_count      = 0;
    int cycle_count    = 0;

    short_term_plasticity_synapse DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic logic [31:0] room_to_one(input logic [31:0] v);
        return (v >= Q15_ONE) ? 32'd0 : (Q15_ONE - v);
    endfunction

    // one time-step update; queues the increment when the source spiked
    function automatic void predict_synapse_update(input logic [15:0] syn,
                                                   input logic [11:0] src,
                                                   input logic [11:0] dst,
                                                   input logic spk);
        logic [31:0] u;
        logic [31:0] x;
        logic [31:0] rel;
        logic [31:0] gain;
        logic [31:0] scaled;
        t_result     res;
        u = {16'd0, util_q15[syn]};
        x = {16'd0, res_q15[syn]};
        u = u - ((u * {16'd0, cfg_decay}) >> 16);
        x = x + ((room_to_one(x) * {16'd0, cfg_recovery}) >> 16);
        if (spk) begin
            u = u + ((room_to_one(u) * {16'd0, cfg_release}) >> 16);
            rel = (u * x) >> 15;
            if (rel > x) begin
                rel = x;
            end
            x = x - rel;
            res.dest = dst;
            res.exc  = ({1'b0, src} < cfg_exc_count);
            gain     = {16'd0, res.exc ? cfg_gain_exc : cfg_gain_inh};
            scaled   = (rel * gain) >> 7;
            if (scaled > INC_CEIL) begin
                scaled = INC_CEIL;
            end
            res.increment = scaled[23:0];
            increment_q.push_back(res);
        end
        util_q15[syn] = u[15:0];
        res_q15[syn]  = x[15:0];
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (increment_q.size() == 0) begin
                $error("result with none expected: dest_neuron %0d increment %0d",
                       m_axis_tdata[11:0], m_axis_tdata[35:12]);
                err_count++;
            end else begin
                want = increment_q.pop_front();
                if (m_axis_tdata[11:0] !== want.dest) begin
                    $error("dest_neuron expected %0d actual %0d", want.dest, m_axis_tdata[11:0]);
                    err_count++;
                end
                if (m_axis_tuser !== want.exc) begin
                    $error("is_excitatory expected %0d actual %0d", want.exc, m_axis_tuser);
                    err_count++;
                end
                if (m_axis_tdata[35:12] !== want.increment) begin
                    $error("increment expected %0d actual %0d",
                           want.increment, m_axis_tdata[35:12]);
                    err_count++;
                end
            end
        end
    end

    task automatic send_update(input logic [15:0] syn, input logic [11:0] src,
                               input logic [11:0] dst, input logic spk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {dst, src, syn};
        s_axis_tuser  <= spk;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_synapse_update(syn, src, dst, spk);
    endtask

    // no spike leaves no result, so the pipeline may still be busy after the last increment
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (increment_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [15:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    task automatic program_cfg(input logic [15:0] decay, input logic [15:0] recovery,
                               input logic [15:0] release_inc, input logic [15:0] gain_exc,
                               input logic [15:0] gain_inh, input logic [12:0] exc_count);
        write_reg(CFG_DECAY, decay);
        write_reg(CFG_RECOVERY, recovery);
        write_reg(CFG_RELEASE, release_inc);
        write_reg(CFG_GAIN_EXC, gain_exc);
        write_reg(CFG_GAIN_INH, gain_inh);
        write_reg(CFG_EXC_COUNT, {3'd0, exc_count});
        i_cfg_we      <= 1'b0;
        cfg_decay     = decay;
        cfg_recovery  = recovery;
        cfg_release   = release_inc;
        cfg_gain_exc  = gain_exc;
        cfg_gain_inh  = gain_inh;
        cfg_exc_count = exc_count;
    endtask

    task automatic set_flow(input t_flow flow);
        case (flow)
            FLOW_FREE: begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            FLOW_SRC_IDLE: begin
                src_idle_pct   = 77;
                sink_stall_pct = 0;
            end
            FLOW_SINK_STALL: begin
                src_idle_pct   = 0;
                sink_stall_pct = 77;
            end
            default: begin
                src_idle_pct   = 37;
                sink_stall_pct = 37;
            end
        endcase
    endtask

    function automatic logic [15:0] pick_q16();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [12:0] pick_exc_count();
        case ($urandom_range(4))
            0: return 13'd0;
            1: return 13'd4096;
            default: return 13'($urandom_range(4096));
        endcase
    endfunction

    // reset configuration: facilitation, depression, recovery and both gain classes
    task automatic test_reset_config();
        set_flow(FLOW_FREE);
        send_update(16'd0, 12'd0, 12'd0, 1'b1);
        send_update(16'd0, 12'd0, 12'd0, 1'b1);
        send_update(16'd0, 12'd0, 12'd0, 1'b0);
        send_update(16'd0, 12'd0, 12'd7, 1'b1);
        send_update(16'hFFFF, 12'hFFF, 12'hFFF, 1'b1);
        send_update(16'd1, 12'd3199, 12'd1, 1'b1);
        send_update(16'd2, 12'd3200, 12'd2, 1'b1);
        send_update(16'hFFFF, 12'hFFF, 12'hFFF, 1'b0);
        send_update(16'hFFFF, 12'hFFF, 12'hABC, 1'b1);
    endtask

    task automatic test_config_extremes();
        settle();
        program_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 13'd4096);
        send_update(16'd3, 12'hFFF, 12'd3, 1'b1);
        send_update(16'd3, 12'hFFF, 12'd3, 1'b1);
        send_update(16'd3, 12'hFFF, 12'd3, 1'b1);
        send_update(16'd4, 12'd0, 12'd4, 1'b1);
        settle();
        program_cfg(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 13'd0);
        send_update(16'd5, 12'd0, 12'd5, 1'b1);
        send_update(16'd3, 12'd0, 12'd3, 1'b1);
        send_update(16'd3, 12'd0, 12'd3, 1'b0);
        settle();
        // no decay and no recovery: repeated spikes drain the resources
        program_cfg(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 13'd2048);
        send_update(16'd6, 12'd2047, 12'd6, 1'b1);
        send_update(16'd6, 12'd2048, 12'd6, 1'b1);
        send_update(16'd6, 12'd2047, 12'd6, 1'b1);
    endtask

    task automatic test_random_traffic(input t_flow flow, input int n_items,
                                       input bit keep_defaults);
        logic [15:0] pool [8];
        logic [15:0] syn;
        logic [11:0] src;
        int          near;
        settle();
        if (keep_defaults) begin
            program_cfg(RST_DECAY, RST_RECOVERY, RST_RELEASE, RST_GAIN_EXC, RST_GAIN_INH,
                        RST_EXC_CNT);
        end else begin
            program_cfg(pick_q16(), pick_q16(), pick_q16(), pick_q16(), pick_q16(),
                        pick_exc_count());
        end
        set_flow(flow);
        for (int p = 0; p < 8; p++) begin
            pool[p] = 16'($urandom);
        end
        pool[0] = 16'd0;
        pool[1] = 16'hFFFF;
        for (int n = 0; n < n_items; n++) begin
            // mostly a few hot synapses so state builds up and back-to-back hazards occur
            if ($urandom_range(99) < 75) begin
                syn = pool[$urandom_range(7)];
            end else begin
                syn = 16'($urandom);
            end
            if ($urandom_range(3) == 0) begin
                near = int'(cfg_exc_count) - 1 + int'($urandom_range(2));
                if (near < 0) begin
                    near = 0;
                end else if (near > 4095) begin
                    near = 4095;
                end
                src = 12'(near);
            end else begin
                src = 12'($urandom);
            end
            send_update(syn, src, 12'($urandom), ($urandom_range(99) < 60));
        end
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_DECAY;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        m_axis_tready <= 1'b0;
        cfg_decay     = RST_DECAY;
        cfg_recovery  = RST_RECOVERY;
        cfg_release   = RST_RELEASE;
        cfg_gain_exc  = RST_GAIN_EXC;
        cfg_gain_inh  = RST_GAIN_INH;
        cfg_exc_count = RST_EXC_CNT;
        for (int s = 0; s < SYN_DEPTH; s++) begin
            util_q15[s] = 16'd0;
            res_q15[s]  = ONE_Q15;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_config();
        test_config_extremes();
        test_random_traffic(FLOW_FREE, 310, 1'b1);
        test_random_traffic(FLOW_SRC_IDLE, 310, 1'b0);
        test_random_traffic(FLOW_SINK_STALL, 310, 1'b0);
        test_random_traffic(FLOW_BOTH_IDLE, 310, 1'b0);
        settle();

        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/stp_pkg.sv
rtl/core/stp_ram.sv
rtl/core/stp_front.sv
rtl/core/stp_back.sv
rtl/core/short_term_plasticity_synapse.sv
tb/sv/tb_short_term_plasticity_synapse.sv
